// ----- rtl/core/sde_pkg.sv -----
`default_nettype none

package sde_pkg;

  localparam int VERTICES_DEF    = 16;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int OUT_CAP         = 16;
  localparam int VX_BITS         = 4;
  localparam int IN_W_BITS       = 16;
  localparam int DIST_BITS       = 24;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam int CNT_BITS        = 5;
  localparam logic [CNT_BITS-1:0] COUNT_RESET = 5'd16;

  localparam logic [1:0] OP_SET          = 2'd0;
  localparam logic [1:0] OP_REMOVE       = 2'd1;
  localparam logic [1:0] OP_REMOVE_MATCH = 2'd2;
  localparam logic [1:0] OP_QUERY        = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam int PC_BITS = 5;
  localparam logic [PC_BITS-1:0] S_CLEAR      = 5'd0;
  localparam logic [PC_BITS-1:0] S_IDLE       = 5'd1;
  localparam logic [PC_BITS-1:0] S_DISPATCH   = 5'd2;
  localparam logic [PC_BITS-1:0] S_EDGE_CHECK = 5'd3;
  localparam logic [PC_BITS-1:0] S_EDGE_KIND  = 5'd4;
  localparam logic [PC_BITS-1:0] S_EDGE_READ  = 5'd5;
  localparam logic [PC_BITS-1:0] S_EDGE_DEL   = 5'd6;
  localparam logic [PC_BITS-1:0] S_EDGE_SET   = 5'd7;
  localparam logic [PC_BITS-1:0] S_EDGE_EMIT  = 5'd8;
  localparam logic [PC_BITS-1:0] S_EDGE_BAD   = 5'd9;
  localparam logic [PC_BITS-1:0] S_Q_CHECK    = 5'd10;
  localparam logic [PC_BITS-1:0] S_Q_INIT     = 5'd11;
  localparam logic [PC_BITS-1:0] S_Q_SCAN     = 5'd12;
  localparam logic [PC_BITS-1:0] S_Q_PICK     = 5'd13;
  localparam logic [PC_BITS-1:0] S_Q_RELAX    = 5'd14;
  localparam logic [PC_BITS-1:0] S_Q_ROUND    = 5'd15;
  localparam logic [PC_BITS-1:0] S_Q_EMIT     = 5'd16;
  localparam logic [PC_BITS-1:0] S_Q_BAD      = 5'd17;

  typedef enum logic [3:0] {
    A_NONE,
    A_CLEAR,
    A_TAKE,
    A_READ_CELL,
    A_REMOVE,
    A_WRITE_CELL,
    A_RANGE_BAD,
    A_EMIT_EDGE,
    A_INIT,
    A_SCAN,
    A_PICK,
    A_RELAX,
    A_NEXT_ROUND,
    A_EMIT_DIST,
    A_EMIT_SRC_BAD
  } act_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_CLR_MORE,
    C_NO_ITEM,
    C_IS_QUERY,
    C_EDGE_BAD,
    C_OP_SET,
    C_SRC_BAD,
    C_NOT_LAST,
    C_FOUND
  } cond_t;

  typedef struct packed {
    act_t               act;
    cond_t              cond;
    logic [PC_BITS-1:0] t_true;
    logic [PC_BITS-1:0] t_false;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input logic [PC_BITS-1:0] step);
    ctrl_t w;
    w = '{act: A_NONE, cond: C_ALWAYS, t_true: S_IDLE, t_false: S_IDLE};
    unique case (step)
      S_CLEAR:      w = '{act: A_CLEAR, cond: C_CLR_MORE, t_true: S_CLEAR, t_false: S_IDLE};
      S_IDLE:       w = '{act: A_TAKE, cond: C_NO_ITEM, t_true: S_IDLE, t_false: S_DISPATCH};
      S_DISPATCH:   w = '{act: A_NONE, cond: C_IS_QUERY, t_true: S_Q_CHECK,
                          t_false: S_EDGE_CHECK};
      S_EDGE_CHECK: w = '{act: A_NONE, cond: C_EDGE_BAD, t_true: S_EDGE_BAD,
                          t_false: S_EDGE_KIND};
      S_EDGE_KIND:  w = '{act: A_NONE, cond: C_OP_SET, t_true: S_EDGE_SET,
                          t_false: S_EDGE_READ};
      S_EDGE_READ:  w = '{act: A_READ_CELL, cond: C_ALWAYS, t_true: S_EDGE_DEL,
                          t_false: S_EDGE_DEL};
      S_EDGE_DEL:   w = '{act: A_REMOVE, cond: C_ALWAYS, t_true: S_EDGE_EMIT,
                          t_false: S_EDGE_EMIT};
      S_EDGE_SET:   w = '{act: A_WRITE_CELL, cond: C_ALWAYS, t_true: S_EDGE_EMIT,
                          t_false: S_EDGE_EMIT};
      S_EDGE_EMIT:  w = '{act: A_EMIT_EDGE, cond: C_ALWAYS, t_true: S_IDLE, t_false: S_IDLE};
      S_EDGE_BAD:   w = '{act: A_RANGE_BAD, cond: C_ALWAYS, t_true: S_EDGE_EMIT,
                          t_false: S_EDGE_EMIT};
      S_Q_CHECK:    w = '{act: A_NONE, cond: C_SRC_BAD, t_true: S_Q_BAD, t_false: S_Q_INIT};
      S_Q_INIT:     w = '{act: A_INIT, cond: C_ALWAYS, t_true: S_Q_SCAN, t_false: S_Q_SCAN};
      S_Q_SCAN:     w = '{act: A_SCAN, cond: C_NOT_LAST, t_true: S_Q_SCAN, t_false: S_Q_PICK};
      S_Q_PICK:     w = '{act: A_PICK, cond: C_FOUND, t_true: S_Q_RELAX, t_false: S_Q_EMIT};
      S_Q_RELAX:    w = '{act: A_RELAX, cond: C_NOT_LAST, t_true: S_Q_RELAX,
                          t_false: S_Q_ROUND};
      S_Q_ROUND:    w = '{act: A_NEXT_ROUND, cond: C_ALWAYS, t_true: S_Q_SCAN,
                          t_false: S_Q_SCAN};
      S_Q_EMIT:     w = '{act: A_EMIT_DIST, cond: C_NOT_LAST, t_true: S_Q_EMIT,
                          t_false: S_IDLE};
      S_Q_BAD:      w = '{act: A_EMIT_SRC_BAD, cond: C_ALWAYS, t_true: S_IDLE, t_false: S_IDLE};
      default:      w = '{act: A_NONE, cond: C_ALWAYS, t_true: S_IDLE, t_false: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/shortest_distance_engine_core.sv -----
// Single-source shortest distances over a directed weighted adjacency matrix held in
// an on-chip memory. An input item sets an edge, removes one, removes one only when
// its weight matches, or runs a distance query from a source; edge operations give
// one result item, a query from a valid source gives one item per vertex in use, in
// index order, with tlast on the final one, and a bad source gives one range item.
// Control is a small microprogram stepping a narrow datapath. Each query round scans
// all vertices in use, one per cycle, for the least distance, then relaxes one matrix
// cell per cycle through the single read port of the edge memory. After reset a
// clearing pass wipes every cell of the edge memory before the first item is taken.
`default_nettype none

module shortest_distance_engine_core
  import sde_pkg::*;
#(
  parameter int VERTICES    = VERTICES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [4:0]    cfg_wr_data,   // vertex_count
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [23:0]   s_axis_tdata,  // from_vertex, to_vertex, weight
  input  wire logic [1:0]    s_axis_tuser,  // operation
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [31:0]        m_axis_tdata,  // vertex, reachable, distance, zero fill
  output logic [1:0]         m_axis_tuser,  // status
  output logic               m_axis_tlast
);

  localparam int NV = (VERTICES < OUT_CAP) ? VERTICES : OUT_CAP;
  localparam int IW = $clog2(NV);
  localparam int CW = IW + 1;
  localparam int AW = 2 * IW;
  localparam int WB = (WEIGHT_BITS < IN_W_BITS) ? WEIGHT_BITS : IN_W_BITS;

  // sequencer
  logic [PC_BITS-1:0] pc, pc_next;
  ctrl_t              cw;
  logic               cond_true, is_emit, out_busy, stall;

  // config and item registers
  logic [CNT_BITS-1:0] vertex_count;
  logic [1:0]          op_q;
  logic [VX_BITS-1:0]  f_q, t_q;
  logic [WB-1:0]       w_q;
  logic [1:0]          st_q;

  // datapath
  logic [CW-1:0]        n, nm1;
  logic [IW-1:0]        i, i_d, cur, ridx;
  logic [DIST_BITS-1:0] cur_d;
  logic                 found, rel_v, at_last;
  logic [AW-1:0]        ctr;
  logic [NV-1:0]        known, vdone;
  logic [DIST_BITS-1:0] best [NV];
  logic [DIST_BITS-1:0] best_rd, nd;
  logic [DIST_BITS:0]   sum;
  logic                 known_rd, cand, rel_upd, del_ok, src_bad, edge_bad;

  // edge memory: present flag over weight
  logic [WB:0]   mem [2**AW];
  logic [WB:0]   mem_q, mem_wdata;
  logic [AW-1:0] mem_waddr, mem_raddr, cell_addr;
  logic          mem_we, mem_re;

  // output register
  logic                 out_valid, out_reach, out_last;
  logic [VX_BITS-1:0]   out_vertex;
  logic [DIST_BITS-1:0] out_dist;
  logic [1:0]           out_status;

  always_comb begin
    if (vertex_count > CNT_BITS'(NV)) begin
      n = CW'(NV);
    end else begin
      n = CW'(vertex_count);
    end
    nm1      = n - CW'(1);
    at_last  = ({1'b0, i} == nm1);
    src_bad  = {1'b0, f_q} >= CNT_BITS'(n);
    edge_bad = src_bad || ({1'b0, t_q} >= CNT_BITS'(n));
  end

  assign cw        = ucode_rom(pc);
  assign is_emit   = (cw.act == A_EMIT_EDGE) || (cw.act == A_EMIT_DIST) ||
                     (cw.act == A_EMIT_SRC_BAD);
  assign out_busy  = out_valid && !m_axis_tready;
  assign stall     = is_emit && out_busy;
  assign cell_addr = {f_q[IW-1:0], t_q[IW-1:0]};

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_CLR_MORE: cond_true = (ctr != {AW{1'b1}});
      C_NO_ITEM:  cond_true = !s_axis_tvalid;
      C_IS_QUERY: cond_true = (op_q == OP_QUERY);
      C_EDGE_BAD: cond_true = edge_bad;
      C_OP_SET:   cond_true = (op_q == OP_SET);
      C_SRC_BAD:  cond_true = src_bad;
      C_NOT_LAST: cond_true = !at_last;
      C_FOUND:    cond_true = found;
      default:    cond_true = 1'b1;
    endcase
    if (stall) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = cw.t_true;
    end else begin
      pc_next = cw.t_false;
    end
  end

  // one read port on the distance store
  always_comb begin
    ridx     = rel_v ? i_d : i;
    best_rd  = best[ridx];
    known_rd = known[ridx];
    cand     = known[i] && !vdone[i] && (!found || (best_rd < cur_d));
    sum      = {1'b0, cur_d} + (DIST_BITS + 1)'(mem_q[WB-1:0]);
    nd       = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
    rel_upd  = rel_v && mem_q[WB] && (!known_rd || (nd < best_rd));
    del_ok   = mem_q[WB] && ((op_q == OP_REMOVE) || (mem_q[WB-1:0] == w_q));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = {1'b0, mem_q[WB-1:0]};
    mem_re    = 1'b0;
    mem_raddr = cell_addr;
    unique case (cw.act)
      A_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ctr;
        mem_wdata = '0;
      end
      A_WRITE_CELL: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, w_q};
      end
      A_REMOVE:    mem_we = del_ok;
      A_READ_CELL: mem_re = 1'b1;
      A_RELAX: begin
        mem_re    = 1'b1;
        mem_raddr = {cur, i};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  assign s_axis_tready = (cw.act == A_TAKE) && !rst;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= S_CLEAR;
      ctr          <= '0;
      vertex_count <= COUNT_RESET;
      out_valid    <= 1'b0;
      known        <= '0;
      vdone        <= '0;
      found        <= 1'b0;
      rel_v        <= 1'b0;
    end else begin
      pc    <= pc_next;
      rel_v <= (cw.act == A_RELAX);
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      if (is_emit && !stall) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cw.act == A_CLEAR) begin
        ctr <= ctr + AW'(1);
      end
      if (rel_upd) begin
        known[i_d] <= 1'b1;
      end
      unique case (cw.act)
        A_INIT: begin
          known <= {{(NV-1){1'b0}}, 1'b1} << f_q[IW-1:0];
          vdone <= '0;
          found <= 1'b0;
        end
        A_SCAN: begin
          if (cand) begin
            found <= 1'b1;
          end
        end
        A_PICK: begin
          if (found) begin
            vdone[cur] <= 1'b1;
          end
        end
        A_NEXT_ROUND: found <= 1'b0;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q <= s_axis_tuser;
      f_q  <= s_axis_tdata[3:0];
      t_q  <= s_axis_tdata[7:4];
      w_q  <= s_axis_tdata[8 +: WB];
    end
    if (rel_upd) begin
      best[i_d] <= nd;
    end
    i_d <= i;
    unique case (cw.act)
      A_REMOVE:     st_q <= del_ok ? ST_DONE : ST_MISMATCH;
      A_WRITE_CELL: st_q <= ST_DONE;
      A_RANGE_BAD:  st_q <= ST_RANGE;
      A_INIT: begin
        best[f_q[IW-1:0]] <= '0;
        i                 <= '0;
      end
      A_SCAN: begin
        i <= i + IW'(1);
        if (cand) begin
          cur   <= i;
          cur_d <= best_rd;
        end
      end
      A_PICK:       i <= '0;
      A_RELAX:      i <= i + IW'(1);
      A_NEXT_ROUND: i <= '0;
      A_EMIT_DIST: begin
        if (!stall) begin
          i <= i + IW'(1);
        end
      end
      default: ;
    endcase
    if (is_emit && !stall) begin
      unique case (cw.act)
        A_EMIT_DIST: begin
          out_vertex <= VX_BITS'(i);
          out_reach  <= known_rd;
          out_dist   <= known_rd ? best_rd : '0;
          out_status <= ST_DONE;
          out_last   <= at_last;
        end
        A_EMIT_SRC_BAD: begin
          out_vertex <= f_q;
          out_reach  <= 1'b0;
          out_dist   <= '0;
          out_status <= ST_RANGE;
          out_last   <= 1'b1;
        end
        default: begin
          out_vertex <= '0;
          out_reach  <= 1'b0;
          out_dist   <= '0;
          out_status <= st_q;
          out_last   <= 1'b1;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_dist, out_reach, out_vertex};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

  // a finished vertex already holds its least distance
  assert property (@(posedge clk) disable iff (rst) rel_upd |-> !vdone[i_d])
    else $error("relaxation improved a finished vertex");

  // the picked vertex is reached and not yet finished
  assert property (@(posedge clk) disable iff (rst)
    (cw.act == A_PICK && found) |-> (known[cur] && !vdone[cur]))
    else $error("picked vertex not a valid candidate");

  // the source is reported reachable at distance zero
  assert property (@(posedge clk) disable iff (rst)
    (cw.act == A_EMIT_DIST && i == f_q[IW-1:0]) |-> (known_rd && best_rd == '0))
    else $error("source distance not zero");

  // no item is taken during the clearing pass or while a result is pending
  assert property (@(posedge clk) disable iff (rst)
    (pc == S_CLEAR || is_emit) |-> !s_axis_tready)
    else $error("item taken while busy");

  // a stalled result step holds its place
  assert property (@(posedge clk) disable iff (rst)
    (is_emit && out_busy) |=> (pc == $past(pc)))
    else $error("result step advanced while output was full");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
  import sde_pkg::*;
();

  localparam int NV = 16;
  localparam logic [4:0] KEEP_COUNT = 5'd0;
  localparam int IDLE_LIMIT = 10000;
  localparam int HOLD_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_ITEMS = 49;
  localparam int DIR_ROWS = 25;

  typedef struct packed {
    logic [3:0]  vertex;
    logic        reachable;
    logic [23:0] distance;
    logic [1:0]  status;
    logic        last;
  } dist_item_t;

  typedef struct packed {
    logic [4:0]  count;
    logic [1:0]  op;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [15:0] weight;
    logic        typed;
    logic [1:0]  status;
    logic [3:0]  vertex;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = COUNT_RESET;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // from_vertex, to_vertex, weight
  logic [1:0]  s_axis_tuser = OP_SET;  // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // vertex, reachable, distance, zero fill
  logic [1:0]  m_axis_tuser;        // status
  logic        m_axis_tlast;

  logic        adj_on [NV][NV];
  logic [15:0] adj_w [NV][NV];
  logic [4:0]  vcount;
  dist_item_t  outcome_q [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;

  // count, op, from, to, weight, typed, status, vertex
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{KEEP_COUNT, OP_QUERY,        4'd0,  4'd0,  16'h0000, 1'b0, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_QUERY,        4'd15, 4'd15, 16'hFFFF, 1'b0, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_REMOVE,       4'd0,  4'd1,  16'h0000, 1'b1, ST_MISMATCH, 4'd0},
    '{KEEP_COUNT, OP_REMOVE_MATCH, 4'd0,  4'd1,  16'h0000, 1'b1, ST_MISMATCH, 4'd0},
    '{KEEP_COUNT, OP_SET,          4'd0,  4'd1,  16'hFFFF, 1'b1, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_SET,          4'd1,  4'd2,  16'hFFFF, 1'b1, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_SET,          4'd15, 4'd15, 16'h0000, 1'b1, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_SET,          4'd0,  4'd15, 16'h0010, 1'b1, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_REMOVE_MATCH, 4'd0,  4'd15, 16'h0011, 1'b1, ST_MISMATCH, 4'd0},
    '{KEEP_COUNT, OP_QUERY,        4'd0,  4'd0,  16'h0000, 1'b0, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_QUERY,        4'd15, 4'd0,  16'h0000, 1'b0, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_REMOVE_MATCH, 4'd0,  4'd15, 16'h0010, 1'b1, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_REMOVE,       4'd1,  4'd2,  16'h0000, 1'b1, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_REMOVE,       4'd1,  4'd2,  16'h0000, 1'b1, ST_MISMATCH, 4'd0},
    '{KEEP_COUNT, OP_SET,          4'd0,  4'd2,  16'h0005, 1'b1, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_SET,          4'd0,  4'd3,  16'h000A, 1'b1, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_SET,          4'd2,  4'd3,  16'h0005, 1'b1, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_QUERY,        4'd0,  4'd0,  16'h0000, 1'b0, ST_DONE,     4'd0},
    '{5'd4,       OP_SET,          4'd5,  4'd0,  16'h0001, 1'b1, ST_RANGE,    4'd0},
    '{KEEP_COUNT, OP_REMOVE,       4'd0,  4'd4,  16'h0000, 1'b1, ST_RANGE,    4'd0},
    '{KEEP_COUNT, OP_QUERY,        4'd7,  4'd0,  16'h0000, 1'b1, ST_RANGE,    4'd7},
    '{KEEP_COUNT, OP_QUERY,        4'd0,  4'd0,  16'h0000, 1'b0, ST_DONE,     4'd0},
    '{5'd1,       OP_QUERY,        4'd0,  4'd0,  16'h0000, 1'b0, ST_DONE,     4'd0},
    '{KEEP_COUNT, OP_SET,          4'd0,  4'd0,  16'hFFFF, 1'b1, ST_DONE,     4'd0},
    '{5'd16,      OP_QUERY,        4'd1,  4'd0,  16'h0000, 1'b0, ST_DONE,     4'd0}
  };

  shortest_distance_engine_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic dist_item_t dist_item(logic [3:0] v, logic r, logic [23:0] d,
                                           logic [1:0] s, logic l);
    dist_item = '{vertex: v, reachable: r, distance: d, status: s, last: l};
  endfunction

  function automatic void queue_result(dist_item_t it);
    outcome_q.insert(outcome_q.size(), it);
  endfunction

  // edge update or single-source distances over the adjacency matrix
  task automatic compute_outcome(input logic [1:0] op, input logic [3:0] src,
                                 input logic [3:0] dst, input logic [15:0] w);
    int          n;
    int          cur;
    logic        found;
    logic [23:0] cur_d;
    logic [24:0] sum;
    logic [23:0] nd;
    logic [1:0]  st;
    logic [23:0] best [NV];
    logic        known [NV];
    logic        visited [NV];
    n = (vcount > NV) ? NV : int'(vcount);
    if (op == OP_QUERY && src >= n) begin
      queue_result(dist_item(src, 1'b0, '0, ST_RANGE, 1'b1));
    end else if (op == OP_QUERY) begin
      for (int i = 0; i < NV; i++) begin
        best[i] = '0;
        known[i] = 1'b0;
        visited[i] = 1'b0;
      end
      known[src] = 1'b1;
      for (int r = 0; r < n; r++) begin
        found = 1'b0;
        cur = 0;
        cur_d = '0;
        for (int i = 0; i < n; i++) begin
          if (known[i] && !visited[i] && (!found || best[i] < cur_d)) begin
            found = 1'b1;
            cur = i;
            cur_d = best[i];
          end
        end
        if (found) begin
          visited[cur] = 1'b1;
          for (int i = 0; i < n; i++) begin
            if (adj_on[cur][i]) begin
              sum = {1'b0, cur_d} + {9'd0, adj_w[cur][i]};
              nd = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[23:0];
              if (!known[i] || nd < best[i]) begin
                best[i] = nd;
                known[i] = 1'b1;
              end
            end
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        queue_result(dist_item(i[3:0], known[i], known[i] ? best[i] : 24'd0,
                               ST_DONE, i == n - 1));
      end
    end else if (src >= n || dst >= n) begin
      queue_result(dist_item(4'd0, 1'b0, '0, ST_RANGE, 1'b1));
    end else begin
      st = ST_DONE;
      if (op == OP_SET) begin
        adj_on[src][dst] = 1'b1;
        adj_w[src][dst] = w;
      end else if (op == OP_REMOVE) begin
        if (adj_on[src][dst]) adj_on[src][dst] = 1'b0;
        else st = ST_MISMATCH;
      end else begin
        if (adj_on[src][dst] && adj_w[src][dst] == w) adj_on[src][dst] = 1'b0;
        else st = ST_MISMATCH;
      end
      queue_result(dist_item(4'd0, 1'b0, '0, st, 1'b1));
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [3:0] src, input logic [3:0] dst,
                           input logic [15:0] w, input logic typed, input logic [1:0] t_status,
                           input logic [3:0] t_vertex);
    int gap;
    int depth;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {w, dst, src};
    s_axis_tuser <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    depth = outcome_q.size();
    compute_outcome(op, src, dst, w);
    if (typed) begin
      while (outcome_q.size() > depth) outcome_q.delete(outcome_q.size() - 1);
      queue_result(dist_item(t_vertex, 1'b0, '0, t_status, 1'b1));
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic set_count(input logic [4:0] n);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vcount = n;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // receiver stall pattern
  initial begin
    int mode;
    int len;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(16, 256);
        for (int k = 0; k < len; k++) begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (k % 5) != 4;
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    dist_item_t got;
    dist_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = dist_item(m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[28:5],
                      m_axis_tuser, m_axis_tlast);
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected item, expected none, got vertex %0d distance %0d",
                 $time, got.vertex, got.distance);
      end else begin
        want = outcome_q.pop_front();
        check_field("vertex", want.vertex, got.vertex);
        check_field("reachable", want.reachable, got.reachable);
        check_field("distance", want.distance, got.distance);
        check_field("status", want.status, got.status);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [1:0]  op;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [15:0] w;
    logic [4:0]  cnt;
    int          pick;
    for (int i = 0; i < NV; i++) begin
      for (int j = 0; j < NV; j++) begin
        adj_on[i][j] = 1'b0;
        adj_w[i][j] = '0;
      end
    end
    vcount = COUNT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].count != KEEP_COUNT) begin
        s_axis_tvalid <= 1'b0;
        set_count(dir_tab[r].count);
      end
      send_item(dir_tab[r].op, dir_tab[r].src, dir_tab[r].dst, dir_tab[r].weight,
                dir_tab[r].typed, dir_tab[r].status, dir_tab[r].vertex);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      s_axis_tvalid <= 1'b0;
      case (p)
        0, 1, 7: cnt = 5'd16;
        2:       cnt = 5'd1;
        3:       cnt = 5'd2;
        8:       cnt = 5'($urandom_range(1, 16));
        default: cnt = 5'($urandom_range(3, 15));
      endcase
      set_count(cnt);
      // long receiver hold while items keep coming
      if (p == 1) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) op = OP_SET;
        else if (pick < 55) op = OP_REMOVE;
        else if (pick < 70) op = OP_REMOVE_MATCH;
        else op = OP_QUERY;
        src = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, int'(cnt) - 1));
        dst = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, int'(cnt) - 1));
        case ($urandom_range(0, 5))
          0, 1:    w = 16'($urandom_range(0, 65535));
          2, 3:    w = 16'($urandom_range(0, 63));
          4:       w = 16'hFFFF;
          default: w = 16'h0000;
        endcase
        if (op == OP_REMOVE_MATCH && adj_on[src][dst] && $urandom_range(0, 1) == 1) begin
          w = adj_w[src][dst];
        end
        send_item(op, src, dst, w, 1'b0, ST_DONE, 4'd0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
